/* rtl/core/environment_sensor_compensation_macros.svh */
// Assertion macros shared by the compensation block.
`ifndef ENVIRONMENT_SENSOR_COMPENSATION_MACROS_SVH
`define ENVIRONMENT_SENSOR_COMPENSATION_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ESC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/core/esc_pkg.sv */
package esc_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned CntW = 6;
	localparam int unsigned RawW = 20;
	localparam int unsigned HumW = 17;
	localparam int unsigned TdataInW = 24;
	localparam int unsigned TdataOutW = 88;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	localparam logic [1:0] ACT_TEMP = 2'd0;
	localparam logic [1:0] ACT_PRES = 2'd1;
	localparam logic [1:0] ACT_HUM = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_TEMP = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PRES_LO = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PRES_HI = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MIXED = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_HUM = 3'd4;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;

	typedef struct packed {
		logic start;
		logic [1:0] op;
	} esc_unit_req_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
		asr = 32'($signed(x) >>> n);
	endfunction
endpackage

/* rtl/core/esc_serial_unit.sv */
// Bit-serial 32x32 multiplier (low word) and 32/32 unsigned divider.
// One bit per cycle while busy after start.
module esc_serial_unit (
	input logic clk,
	input logic arst_n,
	input esc_pkg::esc_unit_req_t req,
	input logic [31:0] a,
	input logic [31:0] b,
	output logic busy,
	output logic [31:0] result
);
	import esc_pkg::*;

	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic [1:0] op_q;
	logic [31:0] acc_q;
	logic [31:0] sa_q;
	logic [31:0] sb_q;
	logic [33:0] rem_next;

	// The shifted remainder can reach 33 bits when the divisor is above 2^31.
	assign rem_next = {1'b0, acc_q, sa_q[31]} - {2'b00, sb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_MUL;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
			op_q <= req.op;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntW'(31)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sa_q <= a;
			sb_q <= b;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				// Shift-and-add on the low word, multiplier taken LSB first.
				if (sb_q[0]) acc_q <= acc_q + sa_q;
				sa_q <= {sa_q[30:0], 1'b0};
				sb_q <= {1'b0, sb_q[31:1]};
			end else begin
				// Restoring division; the quotient bits fill sa_q from the right.
				if (!rem_next[33]) begin
					acc_q <= rem_next[31:0];
					sa_q <= {sa_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], sa_q[31]};
					sa_q <= {sa_q[30:0], 1'b0};
				end
			end
		end
	end

	assign busy = busy_q | req.start;
	assign result = (op_q == OP_MUL) ? acc_q : sa_q;
endmodule

/* rtl/core/environment_sensor_compensation.sv */
// Environment sensor compensation: 32-bit integer temperature, pressure and
// humidity compensation for a combined sensor.
// Input stream s_axis: tdata carries action and raw_sample; one request
// gives exactly one result on m_axis, whose tdata carries kind, temperature,
// pressure and humidity. Action 3 gives kind 3 with all value fields zero.
// Coefficients must be written over the cfg channel (index 0..4) only while
// idle; the block does not enforce this. All multiplications and the one
// division share a bit-serial unit; each operation is issued, steps through
// the operand bits and is collected. A temperature request needs 4
// operations, humidity 8, pressure 11 (6 when the divisor is zero). The input
// is ready again in the same cycle that the result becomes valid, so one
// request is in work at a time. An unused action goes straight to the done
// state without using the unit.
// The result sits in an output register; a new request is taken while it
// waits, but completion of that request holds until m_axis takes the old one.
// Reset clears the coefficients, the stored fine temperature and all control.
module environment_sensor_compensation (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [esc_pkg::TdataInW-1:0] s_axis_tdata, // action[1:0], raw_sample[21:2], zero
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// kind[1:0], temperature[33:2], pressure[65:34], humidity[82:66], zero
	output logic [esc_pkg::TdataOutW-1:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [esc_pkg::CfgIdxW-1:0] cfg_index,
	input logic [esc_pkg::CfgDataW-1:0] cfg_data
);
	import esc_pkg::*;
	`include "environment_sensor_compensation_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [47:0] tc_q, mc_q;
	logic [63:0] pl_q, ph_q;
	logic [39:0] hc_q;
	logic [31:0] fine_q;

	logic [1:0] st_q;
	logic [4:0] step_q;
	logic [1:0] act_q;
	logic [31:0] adc_q;
	logic [31:0] r0_q, r1_q, r2_q, r3_q;
	logic [31:0] res_q;

	logic [1:0] okind_q;
	logic [31:0] otemp_q, opres_q;
	logic [HumW-1:0] ohum_q;
	logic ovalid_q;

	esc_unit_req_t ureq;
	logic [31:0] ua, ub, ures;
	logic ubusy;

	esc_serial_unit u_unit (
		.clk(clk), .arst_n(arst_n), .req(ureq), .a(ua), .b(ub),
		.busy(ubusy), .result(ures)
	);

	// Coefficient fields.
	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	assign t1 = {16'd0, tc_q[15:0]};
	assign t2 = {{16{tc_q[31]}}, tc_q[31:16]};
	assign t3 = {{16{tc_q[47]}}, tc_q[47:32]};
	assign p1 = {16'd0, pl_q[15:0]};
	assign p2 = {{16{pl_q[31]}}, pl_q[31:16]};
	assign p3 = {{16{pl_q[47]}}, pl_q[47:32]};
	assign p4 = {{16{pl_q[63]}}, pl_q[63:48]};
	assign p5 = {{16{ph_q[15]}}, ph_q[15:0]};
	assign p6 = {{16{ph_q[31]}}, ph_q[31:16]};
	assign p7 = {{16{ph_q[47]}}, ph_q[47:32]};
	assign p8 = {{16{ph_q[63]}}, ph_q[63:48]};
	assign p9 = {{16{mc_q[15]}}, mc_q[15:0]};
	assign h1 = {24'd0, mc_q[23:16]};
	assign h2 = {{16{mc_q[39]}}, mc_q[39:24]};
	assign h3 = {24'd0, mc_q[47:40]};
	assign h4 = {{16{hc_q[15]}}, hc_q[15:0]};
	assign h5 = {{16{hc_q[31]}}, hc_q[31:16]};
	assign h6 = {{24{hc_q[39]}}, hc_q[39:32]};

	// Operand selection and bookkeeping per step. Each step issues one unit
	// operation; the post block folds its result into the scratch registers.
	logic [1:0] s_op;
	logic s_last;
	always_comb begin
		s_op = OP_MUL;
		ua = '0;
		ub = '0;
		s_last = 1'b0;
		case (act_q)
			ACT_TEMP: begin
				case (step_q)
					5'd0: begin ua = asr(adc_q, 5'd3) - (t1 << 1); ub = t2; end
					5'd1: begin ua = asr(adc_q, 5'd4) - t1; ub = ua; end
					5'd2: begin ua = asr(res_q, 5'd12); ub = t3; end
					5'd3: begin ua = r0_q + asr(res_q, 5'd14); ub = 32'd5; s_last = 1'b1; end
					default: ;
				endcase
			end
			ACT_PRES: begin
				case (step_q)
					5'd0: begin ua = r0_q; ub = r0_q; end        // q*q, r0=q
					5'd1: begin ua = asr(res_q, 5'd11); ub = p6; end
					5'd2: begin ua = r1_q; ub = p5; end          // r1=v1
					5'd3: begin ua = p3; ub = asr(r3_q, 5'd13); end // r3=q*q
					5'd4: begin ua = p2; ub = r1_q; end
					5'd5: begin ua = 32'd32768 + r1_q; ub = p1; end // r1 = new v1
					5'd6: begin ua = r2_q; ub = 32'd3125; end   // r2 = adc term
					5'd7: begin s_op = OP_DIV; ua = r0_q; ub = r1_q; end
					5'd8: begin ua = r0_q >> 3; ub = r0_q >> 3; end // r0 = p
					5'd9: begin ua = p9; ub = res_q >> 13; end
					5'd10: begin ua = r0_q >> 2; ub = p8; s_last = 1'b1; end
					default: ;
				endcase
			end
			ACT_HUM: begin
				case (step_q)
					5'd0: begin ua = h5; ub = r0_q; end          // r0=v
					5'd1: begin ua = r0_q; ub = h6; end
					5'd2: begin ua = r0_q; ub = h3; end
					5'd3: begin ua = r2_q; ub = asr(res_q, 5'd11) + 32'd32768; end
					5'd4: begin ua = asr(res_q, 5'd10) + 32'd2097152; ub = h2; end
					5'd5: begin ua = r1_q; ub = asr(res_q + 32'd8192, 5'd14); end
					5'd6: begin ua = asr(res_q, 5'd15); ub = ua; end
					5'd7: begin ua = asr(res_q, 5'd7); ub = h1; s_last = 1'b1; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	logic [31:0] tfin, pfin;
	logic [31:0] hv;
	logic [HumW-1:0] hfin;
	logic pres_zero;
	assign tfin = asr(res_q + 32'd128, 5'd8);
	assign pfin = r0_q + asr(r2_q + asr(res_q, 5'd13) + p7, 5'd4);
	assign hv = r3_q - asr(res_q, 5'd4);
	assign hfin = hv[31] ? '0
		: (hv > 32'd419430400) ? HumW'(32'd419430400 >> 12) : HumW'(hv >> 12);
	// A zero pressure divisor ends the request right after it is formed.
	assign pres_zero = (act_q == ACT_PRES) && (step_q == 5'd5)
		&& (asr(ures, 5'd15) == 32'd0);

	logic in_fire, out_fire;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_fire = s_axis_tvalid & s_axis_tready;
	assign out_fire = m_axis_tvalid & m_axis_tready;
	assign cfg_ready = 1'b1;

	assign ureq.start = (st_q == ST_ISSUE);
	assign ureq.op = s_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0; pl_q <= '0; ph_q <= '0; mc_q <= '0; hc_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEMP: tc_q <= cfg_data[47:0];
				REG_PRES_LO: pl_q <= cfg_data;
				REG_PRES_HI: ph_q <= cfg_data;
				REG_MIXED: mc_q <= cfg_data[47:0];
				REG_HUM: hc_q <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= '0;
			ovalid_q <= 1'b0;
			fine_q <= '0;
		end else begin
			if (out_fire && st_q != ST_DONE) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (in_fire) begin
					step_q <= '0;
					st_q <= (s_axis_tdata[1:0] == ACT_UNUSED) ? ST_DONE : ST_ISSUE;
				end
				ST_ISSUE: st_q <= ST_WAIT;
				ST_WAIT: if (!ubusy) begin
					step_q <= step_q + 1'b1;
					st_q <= (s_last || pres_zero) ? ST_DONE : ST_ISSUE;
					if (act_q == ACT_TEMP && step_q == 5'd3) fine_q <= ua;
				end
				ST_DONE: if (!ovalid_q || out_fire) begin
					ovalid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath scratch and result capture.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q <= s_axis_tdata[1:0];
			adc_q <= (s_axis_tdata[1:0] == ACT_HUM) ? {16'd0, s_axis_tdata[17:2]}
				: {12'd0, s_axis_tdata[21:2]};
			if (s_axis_tdata[1:0] == ACT_PRES) begin
				r1_q <= asr(fine_q, 5'd1) - 32'd64000;
				r0_q <= asr(asr(fine_q, 5'd1) - 32'd64000, 5'd2);
			end else begin
				r0_q <= fine_q - 32'd76800;
			end
		end
		if (st_q == ST_WAIT && !ubusy) begin
			res_q <= ures;
			case (act_q)
				ACT_TEMP: if (step_q == 5'd0) r0_q <= asr(ures, 5'd11);
				ACT_PRES: case (step_q)
					5'd0: r3_q <= ures;
					5'd1: r2_q <= ures;
					5'd2: r2_q <= asr(r2_q + (ures << 1), 5'd2) + (p4 << 16);
					5'd3: r3_q <= asr(ures, 5'd3);
					5'd4: r1_q <= asr(r3_q + asr(ures, 5'd1), 5'd18);
					5'd5: begin
						r1_q <= asr(ures, 5'd15);
						r2_q <= (32'd1048576 - adc_q) - asr(r2_q, 5'd12);
					end
					5'd6: begin
						r3_q <= {31'd0, ures[31]};
						r0_q <= ures[31] ? ures : (ures << 1);
					end
					5'd7: r0_q <= r3_q[0] ? (ures << 1) : ures;
					5'd9: r2_q <= asr(ures, 5'd12);
					default: ;
				endcase
				ACT_HUM: case (step_q)
					5'd0: r1_q <= asr(((adc_q << 14) - (h4 << 20) - ures) + 32'd16384,
						5'd15);
					5'd1: r2_q <= asr(ures, 5'd10);
					5'd5: r3_q <= ures;
					default: ;
				endcase
				default: ;
			endcase
		end
		// Only the field that matches the kind carries a value.
		if (st_q == ST_DONE && (!ovalid_q || out_fire)) begin
			okind_q <= act_q;
			otemp_q <= (act_q == ACT_TEMP) ? tfin : '0;
			opres_q <= (act_q == ACT_PRES && r1_q != 32'd0 && step_q == 5'd11) ? pfin : '0;
			ohum_q <= (act_q == ACT_HUM) ? hfin : '0;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {5'd0, ohum_q, opres_q, otemp_q, okind_q};

	`ESC_ASSERT_IMP(a_ready_idle, s_axis_tready, st_q == ST_IDLE, "input ready outside idle")
	`ESC_ASSERT_NEXT(a_one_per_req, in_fire, !s_axis_tready, "second request taken")
	`ESC_ASSERT_IMP(a_unit_start_free, ureq.start, st_q == ST_ISSUE, "unit started late")
	`ESC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

/* tb/environment_sensor_compensation_checker.sv */
module environment_sensor_compensation_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [esc_pkg::TdataInW-1:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [esc_pkg::TdataOutW-1:0] m_axis_tdata,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [esc_pkg::CfgIdxW-1:0] cfg_index,
	input logic [esc_pkg::CfgDataW-1:0] cfg_data,
	output int errors,
	output int pending,
	output int checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import esc_pkg::*;

	typedef struct packed {
		logic [16:0] humidity;
		logic [31:0] pressure;
		logic [31:0] temperature;
		logic [1:0] kind;
	} reading_t;

	logic [63:0] temp_cal, pres_cal_lo, pres_cal_hi, mixed_cal, hum_cal;
	logic [31:0] fine_temp;
	reading_t expected_readings[$];

	function automatic logic [31:0] shr_signed(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	// Updates the stored fine temperature as a side effect.
	function automatic logic [31:0] compensate_temperature(input logic [31:0] adc);
		logic [31:0] t1, t2, t3, a, b, m, v1, v2;
		t1 = {16'd0, temp_cal[15:0]};
		t2 = sext16(temp_cal[31:16]);
		t3 = sext16(temp_cal[47:32]);
		a = (adc >> 3) - (t1 << 1);
		m = a * t2;
		v1 = shr_signed(m, 11);
		b = (adc >> 4) - t1;
		m = b * b;
		m = shr_signed(m, 12) * t3;
		v2 = shr_signed(m, 14);
		fine_temp = v1 + v2;
		m = fine_temp * 32'd5 + 32'd128;
		return shr_signed(m, 8);
	endfunction

	function automatic logic [31:0] compensate_pressure(input logic [31:0] adc);
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] v1, v2, q, m, n, p, ps;
		p1 = {16'd0, pres_cal_lo[15:0]};
		p2 = sext16(pres_cal_lo[31:16]);
		p3 = sext16(pres_cal_lo[47:32]);
		p4 = sext16(pres_cal_lo[63:48]);
		p5 = sext16(pres_cal_hi[15:0]);
		p6 = sext16(pres_cal_hi[31:16]);
		p7 = sext16(pres_cal_hi[47:32]);
		p8 = sext16(pres_cal_hi[63:48]);
		p9 = sext16(mixed_cal[15:0]);
		v1 = shr_signed(fine_temp, 1) - 32'd64000;
		q = shr_signed(v1, 2);
		m = q * q;
		v2 = shr_signed(m, 11) * p6;
		n = v1 * p5;
		v2 = v2 + (n << 1);
		v2 = shr_signed(v2, 2) + (p4 << 16);
		n = shr_signed(m, 13) * p3;
		m = p2 * v1;
		v1 = shr_signed(shr_signed(n, 3) + shr_signed(m, 1), 18);
		m = (32'd32768 + v1) * p1;
		v1 = shr_signed(m, 15);
		// A zero divisor yields zero pressure.
		if (v1 == 0)
			return 32'd0;
		p = ((32'd1048576 - adc) - shr_signed(v2, 12)) * 32'd3125;
		// Large dividends are divided first so the doubling cannot overflow.
		if (p < 32'h8000_0000)
			p = (p << 1) / v1;
		else
			p = (p / v1) * 32'd2;
		ps = p >> 3;
		m = ps * ps;
		m = p9 * (m >> 13);
		v1 = shr_signed(m, 12);
		m = (p >> 2) * p8;
		v2 = shr_signed(m, 13);
		return p + shr_signed(v1 + v2 + p7, 4);
	endfunction

	function automatic logic [16:0] compensate_humidity(input logic [31:0] adc);
		logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, m, s;
		h1 = {24'd0, mixed_cal[23:16]};
		h2 = sext16(mixed_cal[39:24]);
		h3 = {24'd0, mixed_cal[47:40]};
		h4 = sext16(hum_cal[15:0]);
		h5 = sext16(hum_cal[31:16]);
		h6 = {{24{hum_cal[39]}}, hum_cal[39:32]};
		v = fine_temp - 32'd76800;
		m = h5 * v;
		a = shr_signed(((adc << 14) - (h4 << 20) - m) + 32'd16384, 15);
		m = v * h6;
		s = v * h3;
		b = shr_signed(m, 10) * (shr_signed(s, 11) + 32'd32768);
		b = shr_signed(b, 10) + 32'd2097152;
		m = b * h2 + 32'd8192;
		b = shr_signed(m, 14);
		v = a * b;
		s = shr_signed(v, 15);
		m = s * s;
		m = shr_signed(m, 7) * h1;
		v = v - shr_signed(m, 4);
		// Clamp to 0..100 percent before dropping the fraction bits.
		if (v[31])
			v = 32'd0;
		if (v > 32'd419430400)
			v = 32'd419430400;
		return 17'(v >> 12);
	endfunction

	function automatic reading_t predict_reading(input logic [1:0] act, input logic [19:0] raw);
		reading_t r;
		r = '0;
		r.kind = act;
		case (act)
			ACT_TEMP: r.temperature = compensate_temperature({12'd0, raw});
			ACT_PRES: r.pressure = compensate_pressure({12'd0, raw});
			ACT_HUM: r.humidity = compensate_humidity({16'd0, raw[15:0]});
			default: ;
		endcase
		return r;
	endfunction

	reading_t got, want;
	int mismatches;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal = '0;
			pres_cal_lo = '0;
			pres_cal_hi = '0;
			mixed_cal = '0;
			hum_cal = '0;
			fine_temp = '0;
			expected_readings.delete();
			errors <= 0;
			checked <= 0;
			pending <= 0;
		end else begin
			mismatches = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEMP: temp_cal = {16'd0, cfg_data[47:0]};
					REG_PRES_LO: pres_cal_lo = cfg_data;
					REG_PRES_HI: pres_cal_hi = cfg_data;
					REG_MIXED: mixed_cal = {16'd0, cfg_data[47:0]};
					REG_HUM: hum_cal = {24'd0, cfg_data[39:0]};
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_readings.push_back(predict_reading(s_axis_tdata[1:0],
					s_axis_tdata[21:2]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = reading_t'(m_axis_tdata[82:0]);
				checked <= checked + 1;
				if (expected_readings.size() == 0) begin
					$error("result without a pending request: kind %0d", got.kind);
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						mismatches++;
					end
					if (got.temperature !== want.temperature) begin
						$error("temperature: expected %0d, got %0d",
							$signed(want.temperature), $signed(got.temperature));
						mismatches++;
					end
					if (got.pressure !== want.pressure) begin
						$error("pressure: expected %0d, got %0d", want.pressure, got.pressure);
						mismatches++;
					end
					if (got.humidity !== want.humidity) begin
						$error("humidity: expected %0d, got %0d", want.humidity, got.humidity);
						mismatches++;
					end
				end
			end
			if (mismatches != 0)
				errors <= errors + mismatches;
			pending <= expected_readings.size();
		end
	end
endmodule

/* tb/environment_sensor_compensation_tb.sv */
module environment_sensor_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import esc_pkg::*;

	localparam int SettleCycles = 700;
	localparam int CycleLimit = 3000000;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [TdataInW-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [TdataOutW-1:0] m_axis_tdata;
	logic cfg_valid, cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int errors, pending, checked;
	int send_idle_pct, recv_idle_pct;
	int requests_by_kind[4];
	int cycles = 0;

	environment_sensor_compensation dut (.*);

	environment_sensor_compensation_checker checker_i (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_request(input logic [1:0] act, input logic [19:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, raw, act};
		requests_by_kind[act]++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// The first edge lets the count of open requests take in the last one.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic load_coefficients(input logic [63:0] t, pl, ph, mx, h);
		write_reg(REG_TEMP, t);
		write_reg(REG_PRES_LO, pl);
		write_reg(REG_PRES_HI, ph);
		write_reg(REG_MIXED, mx);
		write_reg(REG_HUM, h);
		cfg_valid <= 1'b0;
	endtask

	// Coefficients typical of a real part, so the results stay physical.
	task automatic load_typical();
		load_coefficients({16'd0, -16'sd1000, 16'sd26435, 16'd27504},
			{16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
			{-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
			{16'd0, 8'd0, 16'sd362, 8'd75, 16'sd6000},
			{24'd0, 8'sd30, 16'sd50, 16'sd324});
	endtask

	task automatic random_request();
		int r;
		logic [1:0] act;
		logic [19:0] raw;
		r = $urandom_range(15);
		act = (r < 5) ? ACT_TEMP : (r < 10) ? ACT_PRES : (r < 15) ? ACT_HUM : ACT_UNUSED;
		case ($urandom_range(7))
			0: raw = '0;
			1: raw = '1;
			2, 3: raw = 20'($urandom_range(600000, 300000));
			default: raw = 20'($urandom);
		endcase
		send_request(act, raw);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		send_idle_pct = 26;
		recv_idle_pct = 82;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: zero divisor, stored temperature still zero.
		send_request(ACT_PRES, 20'd0);
		send_request(ACT_HUM, 20'hFFFFF);
		send_request(ACT_UNUSED, 20'hFFFFF);
		send_request(ACT_TEMP, 20'd0);
		drain();

		load_typical();
		send_request(ACT_PRES, 20'd415148);
		send_request(ACT_HUM, 20'd30000);
		send_request(ACT_TEMP, 20'd519888);
		send_request(ACT_TEMP, 20'd0);
		send_request(ACT_TEMP, 20'hFFFFF);
		send_request(ACT_TEMP, 20'd519888);
		send_request(ACT_PRES, 20'd415148);
		// Small raw pressure drives the dividend above bit 31.
		send_request(ACT_PRES, 20'd0);
		send_request(ACT_PRES, 20'hFFFFF);
		send_request(ACT_HUM, 20'd0);
		send_request(ACT_HUM, 20'h0FFFF);
		send_request(ACT_HUM, 20'hF7530);
		send_request(ACT_UNUSED, 20'd0);
		send_request(ACT_UNUSED, 20'h5A5A5);
		drain();

		for (int set = 0; set < 6; set++) begin
			send_idle_pct = (set < 2) ? 26 : (set < 4) ? 82 : 0;
			recv_idle_pct = (set < 2) ? 82 : (set < 4) ? 26 : 0;
			case (set)
				0: load_coefficients('1, '1, '1, '1, '1);
				1: load_coefficients({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
					{4{16'h7FFF}}, {4{16'h7FFF}});
				2: load_coefficients({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
				3: load_coefficients({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
					{4{16'h8000}}, {4{16'h8000}});
				default: load_typical();
			endcase
			repeat (72) random_request();
			drain();
		end

		$display("Sent %0d temperature, %0d pressure, %0d humidity and %0d unused requests,",
			requests_by_kind[0], requests_by_kind[1], requests_by_kind[2], requests_by_kind[3]);
		$display("over seven coefficient sets and three stall patterns; %0d results checked.",
			checked);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* environment_sensor_compensation.f */
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_serial_unit.sv
rtl/core/environment_sensor_compensation.sv
tb/environment_sensor_compensation_checker.sv
tb/environment_sensor_compensation_tb.sv
